>>> rtl/mglm_pkg.sv
// Shared types and constants for the microphone array gated level meter.
// Used by mglm_divider and mic_array_gated_level_meter; depends on nothing.
package mglm_pkg;

    // Fixed field layout of one slot and one result.
    localparam int NUM_FIELDS     = 8;
    localparam int CH_W           = 3;
    localparam int SUM_W          = 32;
    localparam int LEVEL_W        = 8;
    localparam int LEN_W          = 16;
    localparam int THR_W          = 8;
    localparam int QSTEP_W        = 4;
    localparam int OUT_W          = NUM_FIELDS * LEVEL_W;

    // Configuration port.
    localparam int CFG_ADDR_W     = 1;
    localparam int CFG_DATA_W     = 16;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_LENGTH    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_NOISE_THRESHOLD = 1'b1;

    // Reset values of the registers.
    localparam logic [LEN_W-1:0] BLOCK_LENGTH_RST    = 16'd6400;
    localparam logic [THR_W-1:0] NOISE_THRESHOLD_RST = 8'd10;

    // Level limits and channel roles.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 8'd255;
    localparam logic [QSTEP_W-1:0] SAT_STEP       = 4'd8;
    localparam int                 CENTRE_CH      = 1;
    localparam int                 FIRST_GATED_CH = 2;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_ACC       = 5'b00010,
        ST_DIV_START = 5'b00100,
        ST_DIV_WAIT  = 5'b01000,
        ST_EMIT      = 5'b10000
    } state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } div_req_t;

    // Answer of the shared divider.
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/mglm_divider.sv
// Iterative divider giving min(floor(dividend / divisor), 255).
// Depends on mglm_pkg for the request and answer structs.
module mglm_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  mglm_pkg::div_req_t  req,
    output mglm_pkg::div_rsp_t  rsp
);
    import mglm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [LEN_W-1:0]     div_reg;
    logic [QSTEP_W-1:0]   step_reg;
    logic [LEVEL_W-1:0]   q_reg;

    logic [SUM_W-1:0]     shifted;
    logic                 fits;

    // Divisor aligned to the current quotient bit, and the trial compare.
    always_comb
    begin
        shifted = {{(SUM_W-LEN_W){1'b0}}, div_reg} << step_reg;
        fits    = (rem_reg >= shifted);
    end

    // Control: busy while stepping, one-cycle done pulse at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // Saturation test first, then quotient bits 7 down to 0.
                if ((step_reg == SAT_STEP && fits) || step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: one restoring step a cycle on the shared compare and subtract.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.dividend;
            div_reg  <= req.divisor;
            step_reg <= SAT_STEP;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == SAT_STEP)
            begin
                if (fits)
                begin
                    q_reg <= LEVEL_MAX;
                end
                step_reg <= step_reg - 4'd1;
            end
            else
            begin
                if (fits)
                begin
                    rem_reg <= rem_reg - shifted;
                    q_reg[step_reg[2:0]] <= 1'b1;
                end
                if (step_reg != '0)
                begin
                    step_reg <= step_reg - 4'd1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

>>> rtl/mic_array_gated_level_meter.sv
// Top level of the microphone array gated level meter: sequencer, sums,
// one shared saturating adder and the output register. Uses mglm_pkg, mglm_divider.
//
//  Channel  Direction  Word                                Handshake
//  s_axis   in         one slot, 8 samples of SAMPLE_BITS  tvalid/tready
//  m_axis   out        one result, 8 levels of 8 bits      tvalid/tready
//  cfg      in         register index and data             cfg_valid/cfg_ready
//
// A slot that does not end a block passes its channels one per cycle through
// the single saturating adder, then the sequencer goes back to idle.
// A slot that ends a block then sends each channel to the divider in turn,
// a start state and then a wait for its answer, before the result is emitted.
// Reset clears the sums, the slot counter and the registers to 6400 and 10.
// The output register lets a new slot in while a result waits; a second
// result waits in the sequencer until the output register is taken.
module mic_array_gated_level_meter
#(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 16
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    // Fields from bit 0 up: sample_board, sample_centre, sample_mic1 .. sample_mic6.
    input  logic [mglm_pkg::NUM_FIELDS*SAMPLE_BITS-1:0] s_axis_tdata,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // Fields from bit 0 up: level_board, level_centre, level_mic1 .. level_mic6.
    output logic [mglm_pkg::OUT_W-1:0]                  m_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [mglm_pkg::CFG_ADDR_W-1:0]             cfg_addr,
    input  logic [mglm_pkg::CFG_DATA_W-1:0]             cfg_data
);
    import mglm_pkg::*;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    state_t                          state_reg;
    state_t                          state_next;
    logic [CH_W-1:0]                 ch_reg;
    logic [LEN_W-1:0]                block_length_reg;
    logic [THR_W-1:0]                noise_threshold_reg;
    logic [LEN_W-1:0]                slot_count_reg;
    logic [SUM_W-1:0]                sums_reg [NUM_FIELDS];
    logic [LEVEL_W-1:0]              level_reg [NUM_FIELDS];
    logic [NUM_FIELDS*SAMPLE_BITS-1:0] sample_reg;
    logic                            out_valid_reg;
    logic [OUT_W-1:0]                out_data_reg;

    logic [SAMPLE_BITS-1:0]          sample_sel;
    logic [SAMPLE_BITS-1:0]          magnitude;
    logic [SUM_W:0]                  sum_ext;
    logic [SUM_W-1:0]                sum_sat;
    logic [LEN_W-1:0]                len_eff;
    logic [LEN_W:0]                  slot_inc;
    logic                            block_end;
    logic                            out_free;
    logic [OUT_W-1:0]                gated;
    logic                            gate_open;
    logic [LEVEL_W-1:0]              centre;
    div_req_t                        div_req;
    div_rsp_t                        div_rsp;

    // Register writes are taken only between slots, so a slot sees one setting.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Magnitude of the selected sample and the saturating accumulate.
    always_comb
    begin
        sample_sel = sample_reg[ch_reg*SAMPLE_BITS +: SAMPLE_BITS];
        magnitude  = sample_sel[SAMPLE_BITS-1] ? (~sample_sel + 1'b1) : sample_sel;
        sum_ext    = {1'b0, sums_reg[ch_reg]} + (SUM_W+1)'(magnitude);
        sum_sat    = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end

    // Block end test; a zero block length counts as one.
    always_comb
    begin
        len_eff   = (block_length_reg == '0) ? LEN_W'(1) : block_length_reg;
        slot_inc  = {1'b0, slot_count_reg} + (LEN_W+1)'(1);
        block_end = (slot_inc >= {1'b0, len_eff});
        out_free  = !out_valid_reg || m_axis_tready;
    end

    // Centre gate and the packed result word.
    always_comb
    begin
        centre    = level_reg[CENTRE_CH];
        gate_open = (centre > noise_threshold_reg);
        gated     = '0;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            if (i < NUM_CHANNELS)
            begin
                if (i < FIRST_GATED_CH)
                begin
                    gated[i*LEVEL_W +: LEVEL_W] = level_reg[i];
                end
                else if (gate_open && level_reg[i] > centre)
                begin
                    gated[i*LEVEL_W +: LEVEL_W] = level_reg[i] - centre;
                end
            end
        end
    end

    // Divider request for the current channel.
    always_comb
    begin
        div_req.start    = (state_reg == ST_DIV_START);
        div_req.dividend = sums_reg[ch_reg];
        div_req.divisor  = len_eff;
    end

    mglm_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (ch_reg == LAST_CH)
                begin
                    state_next = block_end ? ST_DIV_START : ST_IDLE;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (ch_reg == LAST_CH) ? ST_EMIT : ST_DIV_START;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers, sums and the output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            ch_reg              <= '0;
            block_length_reg    <= BLOCK_LENGTH_RST;
            noise_threshold_reg <= NOISE_THRESHOLD_RST;
            slot_count_reg      <= '0;
            out_valid_reg       <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Register writes.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    REG_BLOCK_LENGTH:    block_length_reg    <= cfg_data;
                    REG_NOISE_THRESHOLD: noise_threshold_reg <= cfg_data[THR_W-1:0];
                    default:             ;
                endcase
            end

            // Result word leaves when taken.
            if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    ch_reg <= '0;
                end
                ST_ACC:
                begin
                    sums_reg[ch_reg] <= sum_sat;
                    if (ch_reg == LAST_CH)
                    begin
                        ch_reg <= '0;
                        if (!block_end)
                        begin
                            slot_count_reg <= slot_inc[LEN_W-1:0];
                        end
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_rsp.done && ch_reg != LAST_CH)
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        slot_count_reg <= '0;
                        for (int i = 0; i < NUM_FIELDS; i++)
                        begin
                            sums_reg[i] <= '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers: slot samples, channel levels, result word.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            sample_reg <= s_axis_tdata;
        end
        if (state_reg == ST_DIV_WAIT && div_rsp.done)
        begin
            level_reg[ch_reg] <= div_rsp.quotient;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_data_reg <= gated;
        end
    end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for mic_array_gated_level_meter: directed table, then random slots.
// Each accepted level word is compared field by field with its table row or a bench model.
// Depends on mglm_pkg and the block's RTL; reads no files.
module tb_top;
    import mglm_pkg::*;

    localparam int SMP_W       = 16;
    localparam int SLOT_W      = NUM_FIELDS * SMP_W;
    localparam int DRAIN_CYC   = 120;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_SLOTS  = 400;
    localparam int CALM_FROM   = 340;

    typedef logic [SLOT_W-1:0] slot_word_t;
    typedef logic [OUT_W-1:0]  level_word_t;

    typedef enum logic {ROW_REG, ROW_SLOT} row_kind_t;

    // One line of the directed table: a register write or a slot.
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] value;
        slot_word_t            samples;
        logic                  has_levels;
        level_word_t           levels;
    } dir_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    slot_word_t  s_axis_tdata  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    level_word_t m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Model state of the meter.
    logic [SUM_W-1:0] mag_sum [NUM_FIELDS];
    logic [LEN_W-1:0] slot_cnt;
    logic [LEN_W-1:0] blk_len;
    logic [THR_W-1:0] gate_thr;

    level_word_t level_q [$];
    dir_row_t    dir_rows [$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          ready_hold   = 0;
    bit          calm         = 1'b0;

    string field_names [NUM_FIELDS] = '{"level_board", "level_centre", "level_mic1",
        "level_mic2", "level_mic3", "level_mic4", "level_mic5", "level_mic6"};

    mic_array_gated_level_meter u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Packs eight samples, board microphone in the lowest bits.
    function automatic slot_word_t slot8(input int b, input int c, input int m1, input int m2,
                                         input int m3, input int m4, input int m5, input int m6);
        return {16'(m6), 16'(m5), 16'(m4), 16'(m3), 16'(m2), 16'(m1), 16'(c), 16'(b)};
    endfunction

    // Packs eight levels, board level in the lowest bits.
    function automatic level_word_t lv8(input int b, input int c, input int m1, input int m2,
                                        input int m3, input int m4, input int m5, input int m6);
        return {8'(m6), 8'(m5), 8'(m4), 8'(m3), 8'(m2), 8'(m1), 8'(c), 8'(b)};
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_ADDR_W-1:0] addr,
                                         input logic [CFG_DATA_W-1:0] value);
        return '{ROW_REG, addr, value, '0, 1'b0, '0};
    endfunction

    function automatic dir_row_t slot_row(input slot_word_t samples, input bit has_levels,
                                          input level_word_t levels);
        return '{ROW_SLOT, '0, '0, samples, has_levels, levels};
    endfunction

    // Mostly small magnitudes of either sign, sometimes a full-scale random word.
    function automatic logic [SMP_W-1:0] pick_sample(input int mag_max);
        logic [SMP_W-1:0] mag;
        if ($urandom_range(0, 4) == 0)
            return SMP_W'($urandom);
        mag = SMP_W'($urandom_range(0, mag_max));
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Accumulates one slot; on the last slot of a block returns the gated levels.
    task automatic accumulate_slot(input slot_word_t slot, output bit emitted,
                                   output level_word_t word);
        logic [LEN_W:0]            eff_len;
        logic [SUM_W:0]            wide;
        logic [SMP_W:0]            mag;
        logic signed [SMP_W-1:0]   smp;
        logic [SUM_W-1:0]          quo;
        logic [LEVEL_W-1:0]        lvl [NUM_FIELDS];
        emitted = 1'b0;
        word    = '0;
        for (int ch = 0; ch < NUM_FIELDS; ch++)
        begin
            smp  = slot[ch*SMP_W +: SMP_W];
            mag  = smp[SMP_W-1] ? ({1'b0, ~smp} + 1'b1) : {1'b0, smp};
            wide = {1'b0, mag_sum[ch]} + (SUM_W+1)'(mag);
            mag_sum[ch] = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
        end
        // A zero block length behaves as a length of one.
        eff_len = (blk_len == '0) ? (LEN_W+1)'(1) : {1'b0, blk_len};
        if (({1'b0, slot_cnt} + (LEN_W+1)'(1)) < eff_len)
        begin
            slot_cnt = slot_cnt + 1'b1;
            return;
        end
        for (int ch = 0; ch < NUM_FIELDS; ch++)
        begin
            quo     = mag_sum[ch] / eff_len;
            lvl[ch] = (quo > LEVEL_MAX) ? LEVEL_MAX : quo[LEVEL_W-1:0];
        end
        // Array channels report only above the noise gate, less the centre level.
        for (int ch = FIRST_GATED_CH; ch < NUM_FIELDS; ch++)
        begin
            if (lvl[CENTRE_CH] > gate_thr)
                lvl[ch] = (lvl[ch] > lvl[CENTRE_CH]) ? lvl[ch] - lvl[CENTRE_CH] : '0;
            else
                lvl[ch] = '0;
        end
        for (int ch = 0; ch < NUM_FIELDS; ch++)
        begin
            word[ch*LEVEL_W +: LEVEL_W] = lvl[ch];
            mag_sum[ch] = '0;
        end
        slot_cnt = '0;
        emitted  = 1'b1;
    endtask

    // Offers one slot, after an optional random gap, and books its expected levels.
    task automatic send_slot(input slot_word_t slot, input level_word_t fixed_levels,
                             input bit use_fixed);
        int          gap;
        bit          emitted;
        level_word_t word;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= slot;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        accumulate_slot(slot, emitted, word);
        if (emitted)
            level_q.push_back(use_fixed ? fixed_levels : word);
    endtask

    // Holds the sender until every level word is back, then lets the block settle.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (level_q.size() != 0);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_addr  <= addr;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (addr == REG_BLOCK_LENGTH)
            blk_len = value[LEN_W-1:0];
        else
            gate_thr = value[THR_W-1:0];
    endtask

    // Result side: random stall bursts, always ready in the final stretch.
    always @(posedge clk)
    begin
        if (calm)
            m_axis_tready <= 1'b1;
        else if (ready_hold > 0)
        begin
            ready_hold    <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            ready_hold    <= $urandom_range(0, 16);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare each accepted level word with the oldest expected one.
    always @(posedge clk)
    begin
        level_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (level_q.size() == 0)
            begin
                $error("unexpected level word %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = level_q.pop_front();
                for (int ch = 0; ch < NUM_FIELDS; ch++)
                begin
                    if (m_axis_tdata[ch*LEVEL_W +: LEVEL_W] !== want[ch*LEVEL_W +: LEVEL_W])
                    begin
                        $error("%s expected %0d got %0d", field_names[ch],
                               want[ch*LEVEL_W +: LEVEL_W], m_axis_tdata[ch*LEVEL_W +: LEVEL_W]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int          sent;
        int          pick;
        int          eff;
        int          count;
        int          centre_max;
        int          spread_max;
        logic [LEN_W-1:0] len;
        logic [THR_W-1:0] thr;
        slot_word_t  slot;
        bit          first;

        blk_len  = BLOCK_LENGTH_RST;
        gate_thr = NOISE_THRESHOLD_RST;
        slot_cnt = '0;
        foreach (mag_sum[ch])
            mag_sum[ch] = '0;

        // Zero length acts as one; silence, full-scale slots, then gating at its edges.
        dir_rows.push_back(reg_row(REG_BLOCK_LENGTH, 16'd0));
        dir_rows.push_back(reg_row(REG_NOISE_THRESHOLD, 16'd0));
        dir_rows.push_back(slot_row('0, 1'b1, lv8(0, 0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(slot_row(slot8(-32768, -32768, -32768, -32768, -32768, -32768,
                                          -32768, -32768), 1'b1, lv8(255, 255, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(slot_row(slot8(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                          32767), 1'b1, lv8(255, 255, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(slot_row(slot8(100, 20, 50, 10, 255, -300, 21, -1), 1'b1,
                                    lv8(100, 20, 30, 0, 235, 235, 1, 0)));
        // Centre level equal to the gate keeps the array channels at zero.
        dir_rows.push_back(reg_row(REG_NOISE_THRESHOLD, 16'd20));
        dir_rows.push_back(slot_row(slot8(100, 20, 50, 10, 255, -300, 21, -1), 1'b1,
                                    lv8(100, 20, 0, 0, 0, 0, 0, 0)));
        // Upper data bits of a threshold write are ignored.
        dir_rows.push_back(reg_row(REG_NOISE_THRESHOLD, 16'hA5FF));
        dir_rows.push_back(slot_row(slot8(32767, -32768, 32767, 32767, 32767, 32767, 32767,
                                          32767), 1'b1, lv8(255, 255, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(reg_row(REG_NOISE_THRESHOLD, 16'h5A13));
        dir_rows.push_back(slot_row(slot8(100, -20, 50, 10, 255, -300, 21, -1), 1'b1,
                                    lv8(100, 20, 30, 0, 235, 235, 1, 0)));
        // Longest block, then lowered mid-block: emits at once, divides by the new length.
        dir_rows.push_back(reg_row(REG_BLOCK_LENGTH, 16'hFFFF));
        dir_rows.push_back(reg_row(REG_NOISE_THRESHOLD, 16'd10));
        dir_rows.push_back(slot_row(slot8(1000, 400, -2000, 3000, -32768, 32767, 0, 77), 0, '0));
        dir_rows.push_back(slot_row(slot8(-1, 1, 700, -650, 20, -20, 450, -900), 0, '0));
        dir_rows.push_back(slot_row(slot8(0, -300, 1500, 2500, 12, -8, 600, 300), 0, '0));
        dir_rows.push_back(reg_row(REG_BLOCK_LENGTH, 16'd2));
        dir_rows.push_back(slot_row(slot8(5, -5, 90, -900, 1300, 80, -70, 60), 0, '0));
        dir_rows.push_back(reg_row(REG_NOISE_THRESHOLD, 16'hFF00));
        dir_rows.push_back(reg_row(REG_BLOCK_LENGTH, 16'd3));
        dir_rows.push_back(slot_row(slot8(-32768, 3, 9, 1, -1, 4, 2, 5), 0, '0));
        dir_rows.push_back(slot_row(slot8(7, -3, 20, 0, 15, -6, 4, 30), 0, '0));
        dir_rows.push_back(slot_row(slot8(-7, 2, 3, 8, -12, 9, 40, -2), 0, '0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
                write_reg(dir_rows[i].addr, dir_rows[i].value);
            else
                send_slot(dir_rows[i].samples, dir_rows[i].levels, dir_rows[i].has_levels);
        end

        // Random phases: often new length and gate, then whole blocks, at times a tail, or 1-6 slots.
        // The final stretch keeps the current settings so the input never pauses.
        sent  = 0;
        first = 1'b1;
        while (sent < RAND_SLOTS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = '0;
            else if (pick == 1)
                len = 16'd1;
            else if (pick == 2)
                len = '1;
            else if (pick < 16)
                len = LEN_W'($urandom_range(2, 8));
            else
                len = LEN_W'($urandom_range(9, 40));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                thr = '0;
            else if (pick == 1)
                thr = '1;
            else
                thr = THR_W'($urandom_range(0, 60));
            if (sent < CALM_FROM && (first || $urandom_range(0, 3) != 0))
                write_reg(REG_BLOCK_LENGTH, len);
            if (sent < CALM_FROM && (first || $urandom_range(0, 3) != 0))
                write_reg(REG_NOISE_THRESHOLD, {8'($urandom_range(0, 255)), thr});
            first = 1'b0;

            eff = (blk_len == '0) ? 1 : int'(blk_len);
            if (eff <= 40)
                count = eff * $urandom_range(1, 3) +
                        (($urandom_range(0, 3) == 0) ? $urandom_range(1, eff) : 0);
            else
                count = $urandom_range(1, 6);
            centre_max = $urandom_range(0, 120);
            spread_max = $urandom_range(0, 800);

            for (int n = 0; n < count && sent < RAND_SLOTS; n++)
            begin
                calm = (sent >= CALM_FROM);
                for (int ch = 0; ch < NUM_FIELDS; ch++)
                    slot[ch*SMP_W +: SMP_W] = pick_sample(ch == CENTRE_CH ? centre_max
                                                                          : spread_max);
                send_slot(slot, '0, 1'b0);
                sent++;
            end
        end

        wait_idle();
        if (mismatches == 0 && level_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/mglm_pkg.sv
rtl/mglm_divider.sv
rtl/mic_array_gated_level_meter.sv
sim/tb_top.sv
